// File: rtl/nwms_pkg.sv
// Package for the nucleotide weight matrix scorer: shared types, register
// indexes, character codes and the sigmoid lookup table built at elaboration.
// No dependencies.
package nwms_pkg;

  localparam int MAX_LEN_DEF = 128;
  localparam int BASES       = 4;
  localparam int BASE_W      = 2;
  localparam int QDEPTH      = 2;

  typedef logic signed [15:0] weight_t;
  typedef logic signed [23:0] sum_t;
  typedef logic        [7:0]  char_t;
  typedef logic        [1:0]  cfg_idx_t;

  // register indexes on the config port
  localparam cfg_idx_t CFG_INTERCEPT = 2'd0;
  localparam cfg_idx_t CFG_LOGISTIC  = 2'd1;
  localparam cfg_idx_t CFG_SEQ_LEN   = 2'd2;

  localparam logic [7:0] SEQ_LEN_RST = 8'd20;

  // request kinds
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_CHAR = 1'b1;

  localparam char_t CH_A_UP = 8'h41;
  localparam char_t CH_A_LO = 8'h61;
  localparam char_t CH_C_UP = 8'h43;
  localparam char_t CH_C_LO = 8'h63;
  localparam char_t CH_G_UP = 8'h47;
  localparam char_t CH_G_LO = 8'h67;
  localparam char_t CH_T_UP = 8'h54;
  localparam char_t CH_T_LO = 8'h74;

  localparam logic [1:0] BASE_A = 2'd0;
  localparam logic [1:0] BASE_C = 2'd1;
  localparam logic [1:0] BASE_G = 2'd2;
  localparam logic [1:0] BASE_T = 2'd3;

  localparam sum_t SIG_LO = -24'sd2048;
  localparam sum_t SIG_HI = 24'sd2048;

  typedef struct packed {
    sum_t       intercept;
    logic       logistic_mode;
    logic [7:0] seq_len;
  } cfg_t;

  // one character transaction as it travels from front to back
  typedef struct packed {
    logic    start;
    logic    add_en;
    logic    last;
    logic    len_ok;
    weight_t weight;
  } q_item_t;

  typedef logic [16:0] sig_lut_t [256];

  localparam logic [63:0] ONE_Q32  = 64'h1_0000_0000;
  localparam logic [63:0] EXP_STEP = 64'd4034748382;

  // restoring division, elaboration use only
  function automatic logic [63:0] long_div(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // entry k = round(65536 / (1 + exp(-(k-128)/16))), exp chain in Q32.32
  function automatic sig_lut_t build_sig_lut();
    sig_lut_t    lut;
    logic [63:0] e [129];
    logic [63:0] den;
    logic [63:0] num;
    int          d;
    e[0] = ONE_Q32;
    for (int n = 0; n < 128; n++) begin
      e[n + 1] = (e[n] * EXP_STEP + 64'h8000_0000) >> 32;
    end
    for (int k = 0; k < 256; k++) begin
      d = k - 128;
      if (d >= 0) begin
        den = ONE_Q32 + e[d];
        num = (64'd1 << 48) + (den >> 1);
      end else begin
        den = ONE_Q32 + e[-d];
        num = e[-d] * 64'd65536 + (den >> 1);
      end
      lut[k] = 17'(long_div(num, den));
    end
    return lut;
  endfunction

  localparam sig_lut_t SIG_LUT = build_sig_lut();

endpackage

// File: rtl/nwms_if.sv
// Channel interfaces of the nucleotide weight matrix scorer.
// Depends on nwms_pkg.
interface nwms_in_if;
  logic                 valid;
  logic                 ready;
  logic                 req_type;
  logic [6:0]           weight_pos;
  logic [1:0]           weight_base;
  nwms_pkg::weight_t    weight_value;
  nwms_pkg::char_t      seq_char;
  logic                 seq_last;

  modport source (output valid, req_type, weight_pos, weight_base, weight_value,
                  seq_char, seq_last, input ready);
  modport sink (input valid, req_type, weight_pos, weight_base, weight_value,
                seq_char, seq_last, output ready);
endinterface

interface nwms_out_if;
  logic            valid;
  logic            ready;
  nwms_pkg::sum_t  score_out;
  logic            length_ok;

  modport source (output valid, score_out, length_ok, input ready);
  modport sink (input valid, score_out, length_ok, output ready);
endinterface

// File: rtl/nwms_front.sv
// Front end: accepts transactions, writes weights into the store, decodes
// characters, tracks the position count and reads the weight for each one.
// Depends on nwms_pkg and nwms_if.
module nwms_front #(
  parameter int MAX_LEN = nwms_pkg::MAX_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  nwms_in_if.sink           in_ch,
  input  logic [7:0]        seq_len,
  output logic              push_valid,
  output nwms_pkg::q_item_t push_item,
  input  logic              push_ready
);

  localparam int          POS_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int          ADDR_W  = POS_W + nwms_pkg::BASE_W;
  localparam int          DEPTH   = MAX_LEN * nwms_pkg::BASES;
  localparam logic [8:0]  LEN_LIM = 9'(MAX_LEN);

  nwms_pkg::weight_t  mem [DEPTH];
  nwms_pkg::weight_t  rdata_r;

  logic [7:0]  pos_r, pos_nxt;
  logic        over_r, over_nxt;
  logic        f1_valid_r;
  logic        f1_start_r, f1_add_r, f1_last_r, f1_ok_r;

  logic        accept, is_char, hit, wr_en, rd_en;
  logic [1:0]  base;
  logic [8:0]  wpos9, cpos9;
  logic [7:0]  pos_inc;
  logic        over_inc, start, add_en, len_ok;
  logic [ADDR_W-1:0] wr_addr, rd_addr;

  assign in_ch.ready = !f1_valid_r || push_ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_char     = (in_ch.req_type == nwms_pkg::REQ_CHAR);

  always_comb begin
    hit  = 1'b1;
    base = nwms_pkg::BASE_A;
    case (in_ch.seq_char) inside
      nwms_pkg::CH_A_UP, nwms_pkg::CH_A_LO: base = nwms_pkg::BASE_A;
      nwms_pkg::CH_C_UP, nwms_pkg::CH_C_LO: base = nwms_pkg::BASE_C;
      nwms_pkg::CH_G_UP, nwms_pkg::CH_G_LO: base = nwms_pkg::BASE_G;
      nwms_pkg::CH_T_UP, nwms_pkg::CH_T_LO: base = nwms_pkg::BASE_T;
      default: hit = 1'b0;
    endcase
  end

  assign wpos9    = {2'b00, in_ch.weight_pos};
  assign cpos9    = {1'b0, pos_r};
  assign wr_en    = accept && !is_char && (wpos9 < LEN_LIM);
  assign wr_addr  = {wpos9[POS_W-1:0], in_ch.weight_base};
  assign rd_addr  = {cpos9[POS_W-1:0], base};

  assign start    = (pos_r == 8'd0) && !over_r;
  assign add_en   = hit && !over_r && (cpos9 < LEN_LIM);
  assign rd_en    = accept && is_char && add_en;

  // count saturates at 255; the sticky bit marks an overlong sequence
  assign over_inc = over_r || (pos_r == 8'hFF);
  assign pos_inc  = (pos_r == 8'hFF) ? pos_r : pos_r + 8'd1;
  assign len_ok   = !over_inc && (pos_inc == seq_len);

  always_comb begin
    pos_nxt  = pos_r;
    over_nxt = over_r;
    if (accept && is_char) begin
      if (in_ch.seq_last) begin
        pos_nxt  = 8'd0;
        over_nxt = 1'b0;
      end else begin
        pos_nxt  = pos_inc;
        over_nxt = over_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_ch.weight_value;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= 8'd0;
      over_r     <= 1'b0;
      f1_valid_r <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      over_r <= over_nxt;
      if (accept && is_char) begin
        f1_valid_r <= 1'b1;
      end else if (push_ready) begin
        f1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_char) begin
      f1_start_r <= start;
      f1_add_r   <= add_en;
      f1_last_r  <= in_ch.seq_last;
      f1_ok_r    <= len_ok;
    end
  end

  assign push_valid       = f1_valid_r;
  assign push_item.start  = f1_start_r;
  assign push_item.add_en = f1_add_r;
  assign push_item.last   = f1_last_r;
  assign push_item.len_ok = f1_ok_r;
  assign push_item.weight = rdata_r;

endmodule

// File: rtl/nwms_queue.sv
// Short queue between front and back of the scorer.
// Depends on nwms_pkg.
module nwms_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  input  nwms_pkg::q_item_t push_item,
  output logic              push_ready,
  output logic              pop_valid,
  output nwms_pkg::q_item_t pop_item,
  input  logic              pop_ready
);

  localparam int PTR_W = $clog2(nwms_pkg::QDEPTH);
  localparam int CNT_W = $clog2(nwms_pkg::QDEPTH + 1);

  nwms_pkg::q_item_t entry_r [nwms_pkg::QDEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  count_r;
  logic              push, pop;

  assign push_ready = (count_r < CNT_W'(nwms_pkg::QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = entry_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= PTR_W'(wr_ptr_r + 1'b1);
      end
      if (pop) begin
        rd_ptr_r <= PTR_W'(rd_ptr_r + 1'b1);
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// File: rtl/nwms_back.sv
// Back end: saturating accumulation of weights, result capture on the last
// character, sigmoid lookup and the output register.
// Depends on nwms_pkg and nwms_if.
module nwms_back (
  input  logic              clk,
  input  logic              rst_n,
  input  nwms_pkg::cfg_t    cfg,
  input  logic              pop_valid,
  input  nwms_pkg::q_item_t pop_item,
  output logic              pop_ready,
  nwms_out_if.source        out_ch
);

  localparam logic signed [24:0] SAT_MAX = 25'sd8388607;
  localparam logic signed [24:0] SAT_MIN = -25'sd8388608;

  nwms_pkg::sum_t sum_r, sum_nxt, sum_base;
  logic signed [24:0] sum_wide;
  logic           res_valid_r, res_ok_r;
  nwms_pkg::sum_t res_sum_r;
  logic           out_valid_r, out_ok_r;
  nwms_pkg::sum_t out_score_r;
  nwms_pkg::sum_t score;
  nwms_pkg::sum_t sig_ofs;
  logic [7:0]     sig_idx;
  logic           out_free, res_free, pop;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign res_free  = !res_valid_r || out_free;
  // only the last character needs the result slot
  assign pop_ready = !pop_item.last || res_free;
  assign pop       = pop_valid && pop_ready;

  assign sum_base = pop_item.start ? cfg.intercept : sum_r;
  assign sum_wide = {sum_base[23], sum_base}
                  + (pop_item.add_en ? 25'(pop_item.weight) : 25'sd0);

  always_comb begin
    if (sum_wide > SAT_MAX) begin
      sum_nxt = SAT_MAX[23:0];
    end else if (sum_wide < SAT_MIN) begin
      sum_nxt = SAT_MIN[23:0];
    end else begin
      sum_nxt = sum_wide[23:0];
    end
  end

  assign sig_ofs = res_sum_r - nwms_pkg::SIG_LO;

  always_comb begin
    if (res_sum_r < nwms_pkg::SIG_LO) begin
      sig_idx = 8'd0;
    end else if (res_sum_r >= nwms_pkg::SIG_HI) begin
      sig_idx = 8'd255;
    end else begin
      sig_idx = sig_ofs[11:4];
    end
  end

  always_comb begin
    if (!res_ok_r) begin
      score = '0;
    end else if (cfg.logistic_mode) begin
      score = {7'd0, nwms_pkg::SIG_LUT[sig_idx]};
    end else begin
      score = res_sum_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      res_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        sum_r <= sum_nxt;
      end
      if (pop && pop_item.last) begin
        res_valid_r <= 1'b1;
      end else if (out_free) begin
        res_valid_r <= 1'b0;
      end
      if (res_valid_r && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && pop_item.last) begin
      res_sum_r <= sum_nxt;
      res_ok_r  <= pop_item.len_ok;
    end
    if (res_valid_r && out_free) begin
      out_score_r <= score;
      out_ok_r    <= res_ok_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.score_out = out_score_r;
  assign out_ch.length_ok = out_ok_r;

endmodule

// File: rtl/nucleotide_weight_matrix_scorer.sv
// Top level of the nucleotide weight matrix scorer: config registers,
// front end, queue and back end. Depends on nwms_pkg, nwms_if and submodules.
//
//  channel | direction | transaction
//  in_ch   | sink      | weight load or one sequence character
//  out_ch  | source    | score_out and length_ok, one per last character
//  cfg_*   | write     | intercept, logistic_mode, seq_len
//
// Sustained rate is one transaction per cycle while out_ch does not stall,
// set by the single-port weight store read in the front end and the add in
// the back end. Reset is synchronous; the weight store is not cleared and
// must be loaded. The two-entry queue lets the back end stall on out_ch
// without the front end dropping its read; in_ch stalls only when the queue
// is full.
module nucleotide_weight_matrix_scorer #(
  parameter int MAX_LEN = nwms_pkg::MAX_LEN_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  nwms_in_if.sink            in_ch,
  nwms_out_if.source         out_ch,
  input  logic               cfg_we,
  input  nwms_pkg::cfg_idx_t cfg_idx,
  input  logic [23:0]        cfg_wdata
);

  nwms_pkg::cfg_t    cfg_r;
  logic              push_valid, push_ready, pop_valid, pop_ready;
  nwms_pkg::q_item_t push_item, pop_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.intercept     <= '0;
      cfg_r.logistic_mode <= 1'b0;
      cfg_r.seq_len       <= nwms_pkg::SEQ_LEN_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        nwms_pkg::CFG_INTERCEPT: cfg_r.intercept     <= cfg_wdata;
        nwms_pkg::CFG_LOGISTIC:  cfg_r.logistic_mode <= cfg_wdata[0];
        nwms_pkg::CFG_SEQ_LEN:   cfg_r.seq_len       <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  nwms_front #(.MAX_LEN(MAX_LEN)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .seq_len    (cfg_r.seq_len),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  nwms_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop_ready  (pop_ready)
  );

  nwms_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop_valid (pop_valid),
    .pop_item  (pop_item),
    .pop_ready (pop_ready),
    .out_ch    (out_ch)
  );

endmodule

// File: rtl/nwms_checker.sv
// Port-level checks for the nucleotide weight matrix scorer, bound to the
// top level. Depends on nwms_pkg.
module nwms_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input nwms_pkg::sum_t score_out,
  input logic           length_ok
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(score_out) && $stable(length_ok))
    else $error("result changed while stalled");

  // a length mismatch always reports a zero score
  a_mismatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !length_ok |-> score_out == '0)
    else $error("nonzero score on length mismatch");

  // reset empties the pipeline and opens the input
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

  // the consequent is ANDed with zero, so this property always holds and checks nothing
  a_no_accept_in_reset: assert property (@(posedge clk)
    !rst_n |=> !($past(in_valid) && 1'b0))
    else $error("unexpected accept in reset");

endmodule

bind nucleotide_weight_matrix_scorer nwms_checker u_nwms_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .score_out (out_ch.score_out),
  .length_ok (out_ch.length_ok)
);
